>>> sv/dpcm_uniform_quantizer_macros.svh
// Assertion helpers for the quantizer controller, the only module that uses them.
// Both use the local clk and rst of the module that expands them.
`ifndef DPCM_UNIFORM_QUANTIZER_MACROS_SVH
`define DPCM_UNIFORM_QUANTIZER_MACROS_SVH

// Same-cycle implication.
`define DPCMQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DPCMQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dpcmq_pkg.sv
package dpcmq_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = 11;
  localparam int CMP_W      = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
  localparam int PIX_W      = 16;
  localparam int SYM_W      = 18;
  localparam int STEP_W     = 15;
  localparam int NUM_W      = 17;
  localparam int CNT_W      = $clog2(NUM_W);
  localparam int PROD_W     = SYM_W + STEP_W + 1;
  localparam int REC_W      = PROD_W + 2;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 2;

  localparam logic [STEP_W-1:0]  STEP_RESET   = STEP_W'(16);
  localparam logic [STEP_W-1:0]  OFFSET_RESET = '0;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET  = WIDTH_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SIZE    = 2'd0,
    REG_RECON_OFFSET = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic load;      // capture an accepted pixel and read the upper neighbor
    logic pred;      // form prediction and error, seed the divider
    logic div_step;  // one divider iteration
    logic mul;       // symbol times step
    logic rec;       // reconstruct, update state, load output register
  } cmd_t;

  typedef struct packed {
    logic div_last;  // current divider iteration is the final one
  } status_t;

endpackage

>>> sv/dpcmq_ctrl.sv
`include "dpcm_uniform_quantizer_macros.svh"

module dpcmq_ctrl
  import dpcmq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output cmd_t    cmd,
  input  status_t status
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PRED = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_REC  = 6'b010000,
    S_SPARE = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    state_next   = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PRED;
        end
      end
      S_PRED: begin
        cmd.pred   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_REC;
      end
      S_REC: begin
        if (slot_free) begin
          cmd.rec    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.rec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `DPCMQ_ASSERT_NOW(a_no_overwrite, cmd.rec, slot_free, "result overwritten before transfer")
  `DPCMQ_ASSERT_NEXT(a_div_exit, state == S_DIV && status.div_last, state == S_MUL, "divider exit lost")
  `DPCMQ_ASSERT_NEXT(a_busy_after_load, cmd.load, state == S_PRED && !in_ready, "accepted while busy")

endmodule

>>> sv/dpcmq_dp.sv
module dpcmq_dp
  import dpcmq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic signed [PIX_W-1:0]  pixel,
  input  logic                     frame_start,
  input  cmd_t                     cmd,
  output status_t                  status,
  output logic signed [SYM_W-1:0]  symbol,
  output logic signed [PIX_W-1:0]  recon_value
);

  // Configuration.
  logic [STEP_W-1:0]  step_size;
  logic [STEP_W-1:0]  recon_offset;
  logic [WIDTH_W-1:0] image_width;

  // Raster state.
  logic [PIX_W-1:0]        above_row [MAX_WIDTH];
  logic signed [PIX_W-1:0] left_value;
  logic [COL_W-1:0]        column;
  logic                    first_row;

  // Per-pixel registers.
  logic signed [PIX_W-1:0] cur_pix;
  logic [COL_W-1:0]        cur_col;
  logic                    cur_fr;
  logic signed [PIX_W-1:0] up_data;
  logic signed [PIX_W-1:0] pred;
  logic                    err_neg;
  logic [NUM_W-1:0]        div_num;
  logic [STEP_W-1:0]       div_rem;
  logic [CNT_W-1:0]        div_cnt;
  logic signed [SYM_W-1:0] sym;
  logic signed [PROD_W-1:0] prod;

  logic [STEP_W-1:0]        step_eff;
  logic [COL_W-1:0]         rd_addr;
  logic signed [PIX_W-1:0]  left_sel;
  logic signed [PIX_W-1:0]  up_sel;
  logic signed [PIX_W:0]    pair_sum;
  logic signed [PIX_W-1:0]  pred_calc;
  logic signed [PIX_W+1:0]  err;
  logic [NUM_W-1:0]         err_mag;
  logic [STEP_W:0]          shifted;
  logic                     q_bit;
  logic [SYM_W-1:0]         q_ext;
  logic signed [SYM_W-1:0]  sym_calc;
  logic signed [REC_W-1:0]  rec_sum;
  logic signed [PIX_W-1:0]  rec_sat;
  logic [CMP_W-1:0]         width_eff;
  logic [CMP_W-1:0]         col_inc;

  assign step_eff = (step_size == '0) ? STEP_W'(1) : step_size;
  assign rd_addr  = frame_start ? '0 : column;

  // Prediction: floored mean of left and upper reconstructions.
  assign left_sel  = (cur_col == '0) ? '0 : left_value;
  assign up_sel    = cur_fr ? '0 : up_data;
  assign pair_sum  = (PIX_W + 1)'(left_sel) + (PIX_W + 1)'(up_sel);
  assign pred_calc = pair_sum[PIX_W:1];
  assign err       = (PIX_W + 2)'(cur_pix) - (PIX_W + 2)'(pred_calc);
  assign err_mag   = err[PIX_W+1] ? NUM_W'(-err) : NUM_W'(err);

  // Restoring divider iteration.
  assign shifted = {div_rem, div_num[NUM_W-1]};
  assign q_bit   = (shifted >= {1'b0, step_eff});

  assign q_ext    = SYM_W'(div_num);
  assign sym_calc = err_neg ? -$signed(q_ext) : $signed(q_ext);

  // Reconstruction with signed offset and saturation.
  always_comb begin
    rec_sum = REC_W'(prod) + REC_W'(pred);
    if (sym > 0) begin
      rec_sum = rec_sum + $signed({{(REC_W - STEP_W){1'b0}}, recon_offset});
    end else if (sym < 0) begin
      rec_sum = rec_sum - $signed({{(REC_W - STEP_W){1'b0}}, recon_offset});
    end
    if (rec_sum > REC_W'(32767)) begin
      rec_sat = 16'sh7FFF;
    end else if (rec_sum < -REC_W'(32768)) begin
      rec_sat = -16'sh8000;
    end else begin
      rec_sat = rec_sum[PIX_W-1:0];
    end
  end

  always_comb begin
    if (image_width == '0) begin
      width_eff = CMP_W'(1);
    end else if (CMP_W'(image_width) > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = CMP_W'(image_width);
    end
  end
  assign col_inc = CMP_W'(cur_col) + CMP_W'(1);

  assign status.div_last = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size    <= STEP_RESET;
      recon_offset <= OFFSET_RESET;
      image_width  <= WIDTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STEP_SIZE:    step_size    <= cfg_data[STEP_W-1:0];
        REG_RECON_OFFSET: recon_offset <= cfg_data[STEP_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Row memory: registered read on capture, write on reconstruction.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      up_data <= above_row[rd_addr];
    end
    if (cmd.rec) begin
      above_row[cur_col] <= rec_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_value <= '0;
      column     <= '0;
      first_row  <= 1'b1;
    end else if (cmd.rec) begin
      left_value <= rec_sat;
      if (col_inc >= width_eff) begin
        column    <= '0;
        first_row <= 1'b0;
      end else begin
        column    <= col_inc[COL_W-1:0];
        first_row <= cur_fr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_pix <= pixel;
      cur_col <= rd_addr;
      cur_fr  <= frame_start | first_row;
    end
    if (cmd.pred) begin
      pred    <= pred_calc;
      err_neg <= err[PIX_W+1];
      div_num <= err_mag + NUM_W'(step_eff >> 1);
      div_rem <= '0;
      div_cnt <= CNT_W'(NUM_W - 1);
    end
    if (cmd.div_step) begin
      div_rem <= q_bit ? STEP_W'(shifted - {1'b0, step_eff}) : shifted[STEP_W-1:0];
      div_num <= {div_num[NUM_W-2:0], q_bit};
      div_cnt <= div_cnt - CNT_W'(1);
    end
    if (cmd.mul) begin
      sym  <= sym_calc;
      prod <= PROD_W'(sym_calc) * PROD_W'($signed({1'b0, step_eff}));
    end
    if (cmd.rec) begin
      symbol      <= sym;
      recon_value <= rec_sat;
    end
  end

endmodule

>>> sv/dpcm_uniform_quantizer.sv
// Closed-loop DPCM encoder with a uniform threshold quantizer. Pixels (signed
// Q11.4) arrive in raster order; each is predicted as the floored mean of its
// reconstructed left and upper neighbors, with borders reading as zero, and
// the prediction error is quantized with the programmed step and rounding
// of half a step. Every pixel yields one transfer on the output channel
// carrying the symbol and the saturated reconstruction. A pixel occupies the
// block from its input transfer until it can take the next one: a capture
// step that reads the row memory, a prediction step, the restoring divider
// that produces one quotient bit per cycle, a multiply step and a reconstruct
// step; the reconstruct step stretches while the previous result still waits
// in the output register. Raising frame_start with a pixel restarts the image
// at row zero, column zero. The row memory needs no clearing after reset:
// the first row never reads it. The user must write the registers through
// cfg_write, cfg_index and cfg_data only while the block is idle; the block
// itself does not enforce this.
module dpcm_uniform_quantizer
  import dpcmq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [PIX_W-1:0]  pixel,
  input  logic                     frame_start,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [SYM_W-1:0]  symbol,
  output logic signed [PIX_W-1:0]  recon_value
);

  // Commands flow from the sequencer to the datapath; the datapath reports
  // only when its divider is on its final iteration.
  cmd_t    cmd;
  status_t status;

  dpcmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath holds the registers, the row memory, the divider and the
  // output register that lets a new pixel start while a result waits.
  dpcmq_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel       (pixel),
    .frame_start (frame_start),
    .cmd         (cmd),
    .status      (status),
    .symbol      (symbol),
    .recon_value (recon_value)
  );

endmodule

>>> verif/testbench.sv
module testbench;
  import dpcmq_pkg::*;

  // The write port has two index bits, so one index names no register at all.
  // A write there must leave every register as it was.
  localparam logic [CFG_IDX_W-1:0] SPARE_INDEX = 2'd3;

  // A pixel keeps the block busy until its result enters the output register,
  // so this pause after the last result leaves the block idle before any register write.
  localparam int SETTLE_CYCLES = 24;

  // The longest quiet stretch in a correct run is the long receiver hold of
  // the back-pressure test plus one pixel's own latency. The limit leaves
  // plenty of room above that.
  localparam int QUIET_LIMIT = 5000;

  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic signed [SYM_W-1:0] code;
    logic signed [PIX_W-1:0] recon;
  } dpcm_code_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_STEP_SIZE;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [PIX_W-1:0]  pixel = '0;
  logic                     frame_start = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [SYM_W-1:0]  symbol;
  logic signed [PIX_W-1:0]  recon_value;

  dpcm_uniform_quantizer u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .symbol      (symbol),
    .recon_value (recon_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the encoder: registers as programmed, the reconstructed
  // row above, the left neighbor and the raster position.
  logic [STEP_W-1:0]        step_reg = STEP_RESET;
  logic [STEP_W-1:0]        offset_reg = OFFSET_RESET;
  logic [WIDTH_W-1:0]       width_reg = WIDTH_RESET;
  logic signed [PIX_W-1:0]  row_mem [MAX_WIDTH];
  bit                       row_written [MAX_WIDTH];
  logic signed [PIX_W-1:0]  left_rec = '0;
  int                       col_pos = 0;
  bit                       top_row = 1'b1;

  // Results the block still owes, oldest first.
  dpcm_code_t pending_codes [$];

  int error_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int scene_level = 0;

  // Encodes one pixel exactly as the block must, and advances the shadow
  // state. The prediction is the floored mean of the left and upper
  // reconstructions; a neighbor outside the image counts as zero.
  function automatic dpcm_code_t encode_pixel(logic signed [PIX_W-1:0] pix, logic fs);
    dpcm_code_t res;
    int width;
    int step;
    int col;
    int left;
    int up;
    int pred;
    int err;
    int mag;
    int sym;
    int rec;
    width = width_reg;
    if (width == 0) width = 1;
    if (width > MAX_WIDTH) width = MAX_WIDTH;
    step = (step_reg == 0) ? 1 : step_reg;
    if (fs) begin
      col_pos = 0;
      top_row = 1'b1;
    end
    col = col_pos;
    left = (col == 0) ? 0 : left_rec;
    up = top_row ? 0 : row_mem[col];
    pred = (left + up) >>> 1;
    err = pix - pred;
    mag = (err < 0) ? -err : err;
    sym = (mag + step / 2) / step;
    if (err < 0) sym = -sym;
    rec = pred + sym * step;
    if (sym > 0) rec = rec + offset_reg;
    else if (sym < 0) rec = rec - offset_reg;
    if (rec > 32767) rec = 32767;
    if (rec < -32768) rec = -32768;
    row_mem[col] = rec[PIX_W-1:0];
    row_written[col] = 1'b1;
    left_rec = rec[PIX_W-1:0];
    col = col + 1;
    // A row also ends here when the width was lowered below the column.
    if (col >= width) begin
      col_pos = 0;
      top_row = 1'b0;
    end else begin
      col_pos = col;
    end
    res.code = sym[SYM_W-1:0];
    res.recon = rec[PIX_W-1:0];
    return res;
  endfunction

  // Picture content: mostly a slow random walk, so that errors stay small and
  // the symbols vary, with jumps over the full range and rail values mixed in.
  function automatic logic signed [PIX_W-1:0] next_pixel();
    int pick;
    logic [PIX_W-1:0] raw;
    pick = $urandom_range(99);
    raw = PIX_W'($urandom());
    if (pick < 60) begin
      scene_level = scene_level + $urandom_range(127) - 64;
      if (scene_level > 32767) scene_level = 32767;
      if (scene_level < -32768) scene_level = -32768;
    end else if (pick < 90) begin
      scene_level = $signed(raw);
    end else begin
      scene_level = ($urandom_range(1) == 1) ? 32767 : -32768;
    end
    return scene_level[PIX_W-1:0];
  endfunction

  // Offers one pixel and waits for its transfer. Valid is only lowered when
  // the sender decides to idle, never in the step where it is raised again.
  // A widened row would read row memory the block never wrote; such a pixel
  // opens a new frame instead.
  task automatic send_pixel(logic signed [PIX_W-1:0] pix, logic fs);
    logic fs_used;
    fs_used = fs | (!top_row && !row_written[col_pos]);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel <= pix;
    frame_start <= fs_used;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_codes.push_back(encode_pixel(pix, fs_used));
  endtask

  // Stops offering, waits for every owed result, then lets the block settle.
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One-cycle register write; only called while the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_STEP_SIZE:    step_reg = data;
      REG_RECON_OFFSET: offset_reg = data;
      REG_IMAGE_WIDTH:  width_reg = data[WIDTH_W-1:0];
      default: ;
    endcase
  endtask

  // Registers at their reset values: step 16, no offset, full row width.
  task automatic test_reset_defaults();
    send_pixel(16'sh7FFF, 1'b1);
    send_pixel(-16'sh8000, 1'b0);
    send_pixel(16'sh0000, 1'b0);
    drain_block();
  endtask

  // Unit step on a two-pixel row. The first rows drive the reconstruction to
  // the bottom rail, so the last column is predicted at the minimum and a
  // pixel at the maximum gives the largest possible symbol.
  task automatic test_symbol_extremes();
    write_reg(REG_STEP_SIZE, 15'd1);
    write_reg(REG_RECON_OFFSET, 15'd0);
    write_reg(REG_IMAGE_WIDTH, 15'd2);
    send_pixel(-16'sh8000, 1'b1);
    send_pixel(-16'sh8000, 1'b0);
    send_pixel(-16'sh8000, 1'b0);
    send_pixel(16'sh7FFF, 1'b0);
    send_pixel(16'sh7FFF, 1'b0);
    send_pixel(-16'sh8000, 1'b0);
    drain_block();
  endtask

  // Widest step with the largest offset: both rails are overshot and the
  // reconstruction must saturate.
  task automatic test_saturation();
    write_reg(REG_STEP_SIZE, 15'h7FFF);
    write_reg(REG_RECON_OFFSET, 15'h7FFF);
    write_reg(REG_IMAGE_WIDTH, 15'd1);
    send_pixel(16'sh7FFF, 1'b1);
    send_pixel(-16'sh8000, 1'b1);
    send_pixel(16'sh0000, 1'b0);
    drain_block();
  endtask

  // A zero step behaves as a step of one, and a zero width as one pixel.
  task automatic test_zero_step_and_width();
    write_reg(REG_STEP_SIZE, 15'd0);
    write_reg(REG_RECON_OFFSET, 15'd5);
    write_reg(REG_IMAGE_WIDTH, 15'd0);
    send_pixel(16'sh1234, 1'b1);
    send_pixel(-16'sh0FED, 1'b0);
    send_pixel(16'sh0003, 1'b0);
    drain_block();
  endtask

  // The width drops below the current column in the middle of a row: that
  // pixel still uses its column and the row ends right after it. A write to
  // the spare index on the way must change nothing.
  task automatic test_width_shrink_mid_row();
    write_reg(REG_STEP_SIZE, 15'd24);
    write_reg(REG_RECON_OFFSET, 15'd2);
    write_reg(REG_IMAGE_WIDTH, 15'd8);
    send_pixel(16'sh0400, 1'b1);
    send_pixel(16'sh0480, 1'b0);
    send_pixel(16'sh0500, 1'b0);
    send_pixel(16'sh0580, 1'b0);
    send_pixel(16'sh0600, 1'b0);
    drain_block();
    write_reg(REG_IMAGE_WIDTH, 15'd3);
    write_reg(SPARE_INDEX, 15'h7FFF);
    send_pixel(16'sh0680, 1'b0);
    send_pixel(16'sh0300, 1'b0);
    send_pixel(16'sh0200, 1'b0);
    drain_block();
  endtask

  // A width above the memory size is used as the memory size: the first row
  // must end after 1024 pixels and the next row read the row above.
  task automatic test_width_clamp();
    write_reg(REG_STEP_SIZE, 15'd64);
    write_reg(REG_RECON_OFFSET, 15'd3);
    write_reg(REG_IMAGE_WIDTH, 15'h07FF);
    send_pixel(next_pixel(), 1'b1);
    repeat (MAX_WIDTH + 1) send_pixel(next_pixel(), 1'b0);
    drain_block();
  endtask

  // Random settings and picture content. Each segment reprograms all three
  // registers while idle, then streams a stretch of pixels that mostly
  // continues the raster, with occasional frame restarts.
  task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
    int sent;
    int seg_len;
    int pick;
    logic [CFG_DATA_W-1:0] data;
    sent = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 40) data = CFG_DATA_W'($urandom_range(64, 1));
      else if (pick < 60) data = CFG_DATA_W'($urandom());
      else if (pick < 70) data = '0;
      else if (pick < 80) data = 15'd1;
      else if (pick < 90) data = 15'h7FFF;
      else data = CFG_DATA_W'($urandom_range(512, 16));
      write_reg(REG_STEP_SIZE, data);
      pick = $urandom_range(99);
      if (pick < 30) data = '0;
      else if (pick < 70) data = CFG_DATA_W'($urandom_range(64));
      else if (pick < 90) data = CFG_DATA_W'($urandom());
      else data = 15'h7FFF;
      write_reg(REG_RECON_OFFSET, data);
      // The bits above the width field are filled at random; the register
      // keeps only its low eleven.
      data = CFG_DATA_W'($urandom());
      pick = $urandom_range(99);
      if (pick < 70) data[WIDTH_W-1:0] = WIDTH_W'($urandom_range(12, 1));
      else if (pick < 90) data[WIDTH_W-1:0] = WIDTH_W'($urandom_range(64, 13));
      else if (pick < 94) data[WIDTH_W-1:0] = '0;
      else if (pick < 97) data[WIDTH_W-1:0] = WIDTH_W'(MAX_WIDTH);
      else data[WIDTH_W-1:0] = WIDTH_W'($urandom_range(2047, MAX_WIDTH + 1));
      write_reg(REG_IMAGE_WIDTH, data);
      seg_len = $urandom_range(8, 3);
      if (seg_len > n_items - sent) seg_len = n_items - sent;
      for (int k = 0; k < seg_len; k++) begin
        if (k == 0) send_pixel(next_pixel(), 1'($urandom_range(1)));
        else send_pixel(next_pixel(), $urandom_range(99) < 4);
      end
      sent = sent + seg_len;
      drain_block();
    end
  endtask

  // The receiver holds off for a long stretch while pixels keep coming, so
  // the output register fills and the block must stall its input.
  task automatic test_backpressure();
    write_reg(REG_STEP_SIZE, 15'd20);
    write_reg(REG_RECON_OFFSET, 15'd4);
    write_reg(REG_IMAGE_WIDTH, 15'd5);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    send_pixel(next_pixel(), 1'b1);
    repeat (14) send_pixel(next_pixel(), 1'b0);
    drain_block();
  endtask

  // Receiver: random idling, or a counted hold when a test asks for one.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every output transfer is matched against the oldest owed result.
  always @(posedge clk) begin : check_results
    dpcm_code_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_codes.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected result: symbol %0d recon %0d", symbol, recon_value);
        end
      end else begin
        want = pending_codes.pop_front();
        if (symbol !== want.code || recon_value !== want.recon) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch: symbol %0d (expected %0d) recon %0d (expected %0d)",
                     symbol, want.code, recon_value, want.recon);
          end
        end
      end
    end
  end

  // Watchdog: too long without a transfer on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      row_written[i] = 1'b0;
      row_mem[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with light idling on both sides.
    send_idle_pct = 10;
    recv_idle_pct = 10;
    test_reset_defaults();
    test_symbol_extremes();
    test_saturation();
    test_zero_step_and_width();
    test_width_shrink_mid_row();
    test_width_clamp();

    // Random part: slow receiver, then slow sender, then no idling at all.
    test_random_traffic(27, 70, 15);
    test_random_traffic(70, 27, 15);
    test_random_traffic(0, 0, 15);
    test_backpressure();

    drain_block();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/dpcmq_pkg.sv
sv/dpcmq_ctrl.sv
sv/dpcmq_dp.sv
sv/dpcm_uniform_quantizer.sv
verif/testbench.sv
